/* rtl/mhd_pkg.sv */
// Shared types, widths and the arctangent table for the magnetometer heading block.
// No dependencies.
`default_nettype none

package mhd_pkg;

  // Fixed-point formats of the vector and angle datapaths
  localparam int ANG_FRAC  = 20;           // angle: units of 2^-20 degree
  localparam int VEC_SCALE = 24;           // vector: fraction bits of x and y
  localparam int TABLE_LEN = 24;           // stages that have a table entry
  localparam int VEC_W     = 44;           // 20 integer bits after gain, 24 fraction
  localparam int ANG_W     = 32;
  localparam int RAW_W     = 16;           // one joined sensor reading

  localparam logic signed [ANG_W-1:0] Z_HALF = ANG_W'(180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] Z_FULL = ANG_W'(360 << ANG_FRAC);

  // State handed from one cell to the next
  typedef struct packed {
    logic                    hold;   // vector on the x axis: cells pass it unchanged
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  // atan(2^-i) in degrees, scaled by 2^20, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:       v = 32'sd47185920;
      1:       v = 32'sd27855475;
      2:       v = 32'sd14718068;
      3:       v = 32'sd7471121;
      4:       v = 32'sd3750058;
      5:       v = 32'sd1876857;
      6:       v = 32'sd938658;
      7:       v = 32'sd469357;
      8:       v = 32'sd234682;
      9:       v = 32'sd117342;
      10:      v = 32'sd58671;
      11:      v = 32'sd29335;
      12:      v = 32'sd14668;
      13:      v = 32'sd7334;
      14:      v = 32'sd3667;
      15:      v = 32'sd1833;
      16:      v = 32'sd917;
      17:      v = 32'sd458;
      18:      v = 32'sd229;
      19:      v = 32'sd115;
      20:      v = 32'sd57;
      21:      v = 32'sd29;
      22:      v = 32'sd14;
      23:      v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/magnetometer_heading_atan2.sv */
// Magnetometer heading: atan2(y,x) + 180 degrees by a pipelined row of CORDIC cells.
// Depends on mhd_pkg, mhd_cell and mhd_round.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   sample   | start / busy       | x_high_byte, x_low_byte, y_high_byte, y_low_byte
//   heading  | done (1-cycle)     | heading_fixed, heading_whole_degrees
//
// One transaction is taken every cycle; busy is always low.
// Registers on the path: one input register, one cell per stage and one output
// register for clamp and rounding.
// Reset (rst, synchronous) clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall: done is high for exactly one cycle per transaction.
`default_nettype none

module magnetometer_heading_atan2
  import mhd_pkg::*;
#(
  parameter int FRACTION_BITS = 7,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] x_high_byte,
  input  wire logic [7:0] x_low_byte,
  input  wire logic [7:0] y_high_byte,
  input  wire logic [7:0] y_low_byte,
  output logic            done,
  output logic [15:0]     heading_fixed,
  output logic [8:0]      heading_whole_degrees
);

  localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int EXT  = VEC_W - (RAW_W + 1) - VEC_SCALE;

  logic signed [RAW_W-1:0] x16;
  logic signed [RAW_W-1:0] y16;
  logic signed [RAW_W:0]   xe;
  logic signed [RAW_W:0]   ye;
  logic signed [RAW_W:0]   xn;
  logic signed [RAW_W:0]   yn;
  logic                    neg;
  logic                    yzero;
  cordic_t                 prep_next;

  logic                    cell_valid [0:NSTG];
  cordic_t                 cell_data  [0:NSTG];

  assign busy = 1'b0;

  // Join bytes and fold the left half plane onto the right
  always_comb begin
    x16   = {x_high_byte, x_low_byte};
    y16   = {y_high_byte, y_low_byte};
    xe    = {x16[RAW_W-1], x16};
    ye    = {y16[RAW_W-1], y16};
    neg   = x16[RAW_W-1];
    yzero = (y16 == '0);
    xn    = neg ? ((RAW_W+1)'(0) - xe) : xe;
    yn    = neg ? ((RAW_W+1)'(0) - ye) : ye;
    prep_next.hold = yzero;
    prep_next.x    = {{EXT{xn[RAW_W]}}, xn, {VEC_SCALE{1'b0}}};
    prep_next.y    = {{EXT{yn[RAW_W]}}, yn, {VEC_SCALE{1'b0}}};
    if (yzero) begin
      prep_next.z = neg ? Z_HALF : '0;
    end else if (neg) begin
      prep_next.z = y16[RAW_W-1] ? -Z_HALF : Z_HALF;
    end else begin
      prep_next.z = '0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid[0] <= 1'b0;
    end else begin
      cell_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cell_data[0] <= prep_next;
  end

  // Row of rotation cells
  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    mhd_cell #(
      .STAGE(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .d_valid(cell_valid[i]),
      .d      (cell_data[i]),
      .q_valid(cell_valid[i+1]),
      .q      (cell_data[i+1])
    );
  end

  // Clamp, round and present the heading
  mhd_round #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_round (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (cell_valid[NSTG]),
    .z                    (cell_data[NSTG].z),
    .out_valid            (done),
    .heading_fixed        (heading_fixed),
    .heading_whole_degrees(heading_whole_degrees)
  );

  // Every result traces back to a transaction taken through the input register, every cell and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, NSTG + 2))
    else $error("result without matching transaction");

  // A zero-y sample with non-negative x enters the cell row held at angle zero (heading 180 degrees)
  a_axis: assert property (@(posedge clk) disable iff (rst)
    (start && yzero && !neg) |=> (cell_data[0].hold && cell_data[0].z == '0))
    else $error("zero-y sample not held at zero angle");

  // The input register never carries a negative x
  a_prep_x: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] |-> !cell_data[0].x[VEC_W-1])
    else $error("negative x entered the cell row");

endmodule

`default_nettype wire

/* rtl/mhd_cell.sv */
// One CORDIC vectoring cell: a rotation by +/- atan(2^-STAGE), registered.
// Depends on mhd_pkg.
`default_nettype none

module mhd_cell
  import mhd_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    d_valid,
  input  wire cordic_t d,
  output logic         q_valid,
  output cordic_t      q
);

  localparam logic signed [ANG_W-1:0] ATAN_I = atan_entry(STAGE);

  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  cordic_t                 q_next;

  // Floor shifts of the incoming vector
  assign xs = $signed(d.x) >>> STAGE;
  assign ys = $signed(d.y) >>> STAGE;

  // Rotate toward the x axis, steered by the sign of y
  always_comb begin
    q_next = d;
    if (!d.hold) begin
      if (!d.y[VEC_W-1]) begin
        q_next.x = d.x + ys;
        q_next.y = d.y - xs;
        q_next.z = d.z + ATAN_I;
      end else begin
        q_next.x = d.x - ys;
        q_next.y = d.y + xs;
        q_next.z = d.z - ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // A held vector passes the cell untouched
  a_hold_pass: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d.hold) |=> (q.hold && q.z == $past(d.z) && q.x == $past(d.x)))
    else $error("held transaction modified by cell");

  // x stays non-negative through a rotation
  a_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    (d_valid && !d.hold && !d.x[VEC_W-1]) |=> !q.x[VEC_W-1])
    else $error("cell x went negative");

  // Valid follows the upstream valid in the cycle after it
  a_valid_delay: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> $past(d_valid))
    else $error("cell valid without upstream valid");

endmodule

`default_nettype wire

/* rtl/mhd_round.sv */
// Output stage: offset by 180 degrees, clamp to 0..360, round to FRACTION_BITS.
// Depends on mhd_pkg.
`default_nettype none

module mhd_round
  import mhd_pkg::*;
#(
  parameter int FRACTION_BITS = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic signed [ANG_W-1:0] z,
  output logic                         out_valid,
  output logic [15:0]                  heading_fixed,
  output logic [8:0]                   heading_whole_degrees
);

  localparam int                SHIFT  = ANG_FRAC - FRACTION_BITS;
  localparam logic [ANG_W-1:0]  RND    = ANG_W'(1) << (SHIFT - 1);
  localparam logic [ANG_W-1:0]  HF_MAX = ANG_W'(360) << FRACTION_BITS;

  logic signed [ANG_W-1:0] h;
  logic [ANG_W-1:0]        hc;
  logic [ANG_W-1:0]        hf;
  logic [ANG_W-1:0]        hf_sat;

  // Offset and clamp to the heading range
  always_comb begin
    h = z + Z_HALF;
    if (h[ANG_W-1]) begin
      hc = '0;
    end else if (h > Z_FULL) begin
      hc = Z_FULL;
    end else begin
      hc = h;
    end
    hf     = (hc + RND) >> SHIFT;
    hf_sat = (hf > HF_MAX) ? HF_MAX : hf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    heading_fixed         <= hf_sat[15:0];
    heading_whole_degrees <= hf_sat[FRACTION_BITS +: 9];
  end

  // Whole degrees never exceed a full turn
  a_whole_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_whole_degrees <= 9'd360))
    else $error("heading out of range");

  // A result follows an incoming angle in the cycle after it
  a_out_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid))
    else $error("result without incoming angle");

  // Offset angle of zero or below gives heading zero
  a_clamp_low: assert property (@(posedge clk) disable iff (rst)
    (in_valid && h[ANG_W-1]) |=> (heading_fixed == 16'd0))
    else $error("negative heading not clamped");

endmodule

`default_nettype wire

/* tb/heading_checker.sv */
// Scoreboard for the magnetometer heading block: predicts each heading from the
// sampled sensor bytes with its own CORDIC model and compares every result in order.
// No dependencies on the RTL beyond its port list.
module heading_checker #(
  parameter int FRACTION_BITS = 7,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  x_high_byte,
  input  logic [7:0]  x_low_byte,
  input  logic [7:0]  y_high_byte,
  input  logic [7:0]  y_low_byte,
  input  logic        done,
  input  logic [15:0] heading_fixed,
  input  logic [8:0]  heading_whole_degrees,
  output int          mismatch_count,
  output int          headings_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_FRAC = 20;   // angle accumulator: 2^-20 degree
  localparam int VEC_FRAC   = 24;   // vector fraction bits
  localparam int MAX_STAGES = 24;

  typedef struct packed {
    logic [15:0] x_raw;
    logic [15:0] y_raw;
    logic [15:0] fixed;
    logic [8:0]  whole;
  } heading_exp_t;

  heading_exp_t expected_headings[$];
  int           fail_tally = 0;

  // atan(2^-i) in degrees, scaled by 2^20
  function automatic longint atan_step_deg(input int idx);
    case (idx)
      0:  return 47185920;
      1:  return 27855475;
      2:  return 14718068;
      3:  return 7471121;
      4:  return 3750058;
      5:  return 1876857;
      6:  return 938658;
      7:  return 469357;
      8:  return 234682;
      9:  return 117342;
      10: return 58671;
      11: return 29335;
      12: return 14668;
      13: return 7334;
      14: return 3667;
      15: return 1833;
      16: return 917;
      17: return 458;
      18: return 229;
      19: return 115;
      20: return 57;
      21: return 29;
      22: return 14;
      23: return 7;
      default: return 0;
    endcase
  endfunction

  // Vectoring CORDIC on the joined readings, then clamp and round half up
  function automatic heading_exp_t predict_heading(input logic [15:0] x_raw,
                                                   input logic [15:0] y_raw);
    heading_exp_t e;
    longint       vx, vy, ang, sx, sy, h, hf, half_turn;
    int           n;
    half_turn = longint'(180) <<< ANGLE_FRAC;
    vx  = longint'($signed(x_raw));
    vy  = longint'($signed(y_raw));
    ang = 0;
    n   = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    if (vy == 0) begin
      // on the x axis: exact angle, no rotation
      ang = (vx >= 0) ? 0 : half_turn;
    end else begin
      // left half plane: fold over and start from +/-180
      if (vx < 0) begin
        ang = (vy >= 0) ? half_turn : -half_turn;
        vx  = -vx;
        vy  = -vy;
      end
      vx = vx <<< VEC_FRAC;
      vy = vy <<< VEC_FRAC;
      for (int i = 0; i < n; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy >= 0) begin
          vx  = vx + sy;
          vy  = vy - sx;
          ang = ang + atan_step_deg(i);
        end else begin
          vx  = vx - sy;
          vy  = vy + sx;
          ang = ang - atan_step_deg(i);
        end
      end
    end
    h = ang + half_turn;
    if (h < 0) h = 0;
    if (h > (longint'(360) <<< ANGLE_FRAC)) h = longint'(360) <<< ANGLE_FRAC;
    hf = (h + (longint'(1) <<< (ANGLE_FRAC - FRACTION_BITS - 1)))
         >>> (ANGLE_FRAC - FRACTION_BITS);
    if (hf > (longint'(360) <<< FRACTION_BITS)) hf = longint'(360) <<< FRACTION_BITS;
    e.x_raw = x_raw;
    e.y_raw = y_raw;
    e.fixed = hf[15:0];
    e.whole = 9'((hf >>> FRACTION_BITS) & 64'h1ff);
    return e;
  endfunction

  // Record each accepted sample, check each heading against the oldest prediction
  always @(posedge clk) begin
    heading_exp_t exp_h;
    if (rst) begin
      expected_headings.delete();
    end else begin
      if (start && !busy)
        expected_headings.push_back(predict_heading({x_high_byte, x_low_byte},
                                                    {y_high_byte, y_low_byte}));
      if (done) begin
        if (expected_headings.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("%0t: unexpected heading transaction fixed=%0d whole=%0d",
                     $realtime, heading_fixed, heading_whole_degrees);
        end else begin
          exp_h = expected_headings.pop_front();
          if (heading_fixed !== exp_h.fixed || heading_whole_degrees !== exp_h.whole) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display("%0t: x=%h y=%h heading_fixed exp %0d got %0d, whole exp %0d got %0d",
                       $realtime, exp_h.x_raw, exp_h.y_raw, exp_h.fixed, heading_fixed,
                       exp_h.whole, heading_whole_degrees);
          end
        end
      end
    end
    mismatch_count   <= fail_tally;
    headings_pending <= expected_headings.size();
  end

endmodule

/* tb/tb_magnetometer_heading_atan2.sv */
// Top of the magnetometer heading testbench: clock, reset, sample stimulus and verdict.
// Depends on magnetometer_heading_atan2 (and mhd_pkg) and on heading_checker.
module tb_magnetometer_heading_atan2;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRACTION_BITS = 7;
  localparam int CORDIC_STAGES = 16;
  localparam int RANDOM_SAMPLES = 1500;
  localparam int CALM_TAIL      = 200;   // last samples sent back to back

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  x_high_byte, x_low_byte, y_high_byte, y_low_byte;
  logic        done;
  logic [15:0] heading_fixed;
  logic [8:0]  heading_whole_degrees;
  int          mismatch_count;
  int          headings_pending;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  magnetometer_heading_atan2 #(
    .FRACTION_BITS(FRACTION_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_high_byte(x_high_byte), .x_low_byte(x_low_byte),
    .y_high_byte(y_high_byte), .y_low_byte(y_low_byte),
    .done(done), .heading_fixed(heading_fixed),
    .heading_whole_degrees(heading_whole_degrees)
  );

  heading_checker #(
    .FRACTION_BITS(FRACTION_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_high_byte(x_high_byte), .x_low_byte(x_low_byte),
    .y_high_byte(y_high_byte), .y_low_byte(y_low_byte),
    .done(done), .heading_fixed(heading_fixed),
    .heading_whole_degrees(heading_whole_degrees),
    .mismatch_count(mismatch_count), .headings_pending(headings_pending)
  );

  // Present one sample and hold it until the block takes the transaction
  task automatic send_sample(input logic [15:0] x_raw, input logic [15:0] y_raw);
    start       <= 1'b1;
    x_high_byte <= x_raw[15:8];
    x_low_byte  <= x_raw[7:0];
    y_high_byte <= y_raw[15:8];
    y_low_byte  <= y_raw[7:0];
    do @(posedge clk); while (busy);
  endtask

  // Idle burst with junk on the data ports
  task automatic idle_burst(input int cycles);
    start       <= 1'b0;
    x_high_byte <= 8'($urandom);
    x_low_byte  <= 8'($urandom);
    y_high_byte <= 8'($urandom);
    y_low_byte  <= 8'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [15:0] small_reading();
    return 16'($signed($urandom_range(0, 32)) - 16);
  endfunction

  function automatic logic [15:0] corner_reading();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h8001;
      3:       return 16'h0000;
      4:       return 16'h0001;
      default: return 16'hffff;
    endcase
  endfunction

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [15:0] xr, yr;
    bit          gappy;
    start       <= 1'b0;
    rst         <= 1'b1;
    x_high_byte <= '0;
    x_low_byte  <= '0;
    y_high_byte <= '0;
    y_low_byte  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: origin, both axes, quadrant corners, byte extremes
    send_sample(16'h0000, 16'h0000);   // atan2(0,0) -> 180
    send_sample(16'd100,  16'h0000);   // positive x axis
    send_sample(16'hff9c, 16'h0000);   // negative x axis -> 360
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h7fff, 16'h0000);
    send_sample(16'h0000, 16'h7fff);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'hffff, 16'h0001);   // x = -1, y = 1: atan2 of 135 degrees, heading 315
    send_sample(16'hffff, 16'hffff);
    send_sample(16'h8000, 16'h0001);
    send_sample(16'h8000, 16'hffff);   // just below -x: near 0
    send_sample(16'h0001, 16'h0001);
    send_sample(16'h0001, 16'hffff);
    send_sample(16'h00ff, 16'hff00);
    send_sample(16'hff00, 16'h00ff);
    send_sample(16'h5a5a, 16'ha5a5);
    idle_burst(3);

    // Random: mix of full-range, small, near-axis, diagonal and corner readings
    gappy = 1'b1;
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n % 100 == 0) gappy = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          xr = 16'($urandom);
          yr = 16'($urandom);
        end
        4, 5: begin
          xr = small_reading();
          yr = small_reading();
        end
        6: begin
          xr = 16'($urandom);
          yr = 16'($signed($urandom_range(0, 2)) - 1);
        end
        7: begin
          xr = 16'($signed($urandom_range(0, 2)) - 1);
          yr = 16'($urandom);
        end
        8: begin
          xr = 16'($urandom_range(0, 32767));
          yr = $urandom_range(0, 1) ? xr : -xr;
          if ($urandom_range(0, 1)) xr = -xr;
        end
        default: begin
          xr = corner_reading();
          yr = corner_reading();
        end
      endcase
      send_sample(xr, yr);
      if (gappy && n < RANDOM_SAMPLES - CALM_TAIL && $urandom_range(0, 5) == 0)
        idle_burst($urandom_range(1, 8));
    end
    start <= 1'b0;

    // Drain the pipeline, then allow a few spare cycles for strays
    while (headings_pending != 0) @(posedge clk);
    repeat (CORDIC_STAGES + 6) @(posedge clk);
    if (mismatch_count == 0 && headings_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
